// ===== rtl/core/vsmb_pkg.sv =====
package vsmb_pkg;

  // fixed-point and id widths
  localparam int FRAC_BITS = 12;
  localparam int ID_BITS   = 8;
  localparam int QW        = FRAC_BITS + 1;
  localparam int FUNC_W    = 3;
  localparam int DUR_W     = 16;
  localparam int STEP_W    = 10;
  localparam int KIND_W    = 2;
  localparam int CNT_W     = $clog2(FRAC_BITS + 1);

  localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] HALF_Q = QW'(1) << (FRAC_BITS - 1);

  // command codes
  localparam logic [FUNC_W-1:0] FN_STAGE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CUT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_AUTO  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FTB   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SWAP  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_REPL  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd6;

  // transition kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AUTO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FTB  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FFB  = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SAMPLE,
    ST_RESP
  } state_e;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] dividend;
    logic [DUR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/vsmb_if.sv =====
// command words in
interface vsmb_in_if;
  import vsmb_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_BITS-1:0] look_id;
  logic [DUR_W-1:0]  duration_ms;
  logic [STEP_W-1:0] step_ms;
  modport source (output valid, func, look_id, duration_ms, step_ms, input ready);
  modport sink   (input valid, func, look_id, duration_ms, step_ms, output ready);
endinterface

// status words out
interface vsmb_out_if;
  import vsmb_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] program_look;
  logic [ID_BITS-1:0] preview_look;
  logic [QW-1:0]      opacity;
  logic [QW-1:0]      progress;
  logic [KIND_W-1:0]  kind;
  logic               ftb_active;
  logic               took_program;
  logic               ended;
  logic               ignored;
  modport source (output valid, program_look, preview_look, opacity, progress, kind,
                  ftb_active, took_program, ended, ignored, input ready);
  modport sink   (input valid, program_look, preview_look, opacity, progress, kind,
                  ftb_active, took_program, ended, ignored, output ready);
endinterface

// configuration write words
interface vsmb_cfg_if;
  import vsmb_pkg::*;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] min_duration_ms;
  modport source (output valid, min_duration_ms, input ready);
  modport sink   (input valid, min_duration_ms, output ready);
endinterface

// ===== rtl/core/vsmb_div.sv =====
module vsmb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vsmb_pkg::div_req_t req_i,
  output vsmb_pkg::div_rsp_t rsp_o
);
  import vsmb_pkg::*;

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DUR_W-1:0] rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [DUR_W:0]   shifted;
  logic [DUR_W:0]   diff;

  // one restoring step per cycle
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, req_i.divisor};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      if (req_i.dividend >= req_i.divisor) begin
        // quotient at or above one saturates
        quo_d  = ONE_Q;
        done_d = 1'b1;
        run_d  = 1'b0;
      end else begin
        rem_d = req_i.dividend;
        quo_d = '0;
        cnt_d = CNT_W'(FRAC_BITS);
        run_d = 1'b1;
      end
    end else if (run_q) begin
      if (shifted >= {1'b0, req_i.divisor}) begin
        rem_d = diff[DUR_W-1:0];
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DUR_W-1:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && (cnt_q == CNT_W'(1)) && !req_i.start |=> done_q)
    else $error("divider did not finish after last step");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> quo_q <= ONE_Q)
    else $error("progress quotient above one");

  a_no_start_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !req_i.start)
    else $error("divider restarted while running");

endmodule

// ===== rtl/core/video_switcher_me_bus_unit.sv =====
// channel | dir | words carried
// in_i    | in  | func, look_id, duration_ms, step_ms
// out_o   | out | program_look, preview_look, opacity, progress, kind, flags
// cfg_i   | in  | min_duration_ms, always ready
//
// a word without a progress sample goes from accept through exec to the output register;
// a transition start or a running tick passes exec, 12 restoring divider steps, done,
// sample and load (no steps when elapsed already reaches the length and t saturates)
// one command at a time: in_i is ready only in the idle state, in the cycle after the load
// a full output register holds the sequencer in the response state until out_o is taken
// reset leaves both buses empty, no transition, opacity fully opaque, minimum 60 ms
module video_switcher_me_bus_unit (
  input  logic clk_i,
  input  logic rst_ni,
  vsmb_in_if.sink    in_i,
  vsmb_out_if.source out_o,
  vsmb_cfg_if.sink   cfg_i
);
  import vsmb_pkg::*;

  state_e state_q, state_d;

  logic [DUR_W-1:0]   min_dur_q;
  logic [ID_BITS-1:0] prog_q, prog_d;
  logic [ID_BITS-1:0] prev_q, prev_d;
  logic               fade_q, fade_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [DUR_W-1:0]   len_q, len_d;
  logic [DUR_W-1:0]   elapsed_q, elapsed_d;
  logic               mid_q, mid_d;
  logic [QW-1:0]      level_q, level_d;
  logic               took_q, took_d;
  logic               end_q, end_d;
  logic               ign_q, ign_d;
  logic [QW-1:0]      t_q, t_d;

  logic [FUNC_W-1:0]  func_q;
  logic [ID_BITS-1:0] look_q;
  logic [DUR_W-1:0]   dur_q;
  logic [STEP_W-1:0]  step_q;

  logic               out_valid_q, out_valid_d;
  logic               out_load;

  logic               busy;
  logic [DUR_W-1:0]   len_pick;
  logic [DUR_W-1:0]   len_new;
  logic [DUR_W:0]     elapsed_sum;
  logic [DUR_W-1:0]   elapsed_sat;
  logic [QW:0]        twice_t;

  div_req_t div_req;
  div_rsp_t div_rsp;

  vsmb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // handshakes
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // shared helpers
  assign busy        = (kind_q != KIND_NONE);
  assign len_pick    = (dur_q > min_dur_q) ? dur_q : min_dur_q;
  assign len_new     = (len_pick == '0) ? DUR_W'(1) : len_pick;
  assign elapsed_sum = {1'b0, elapsed_q} + (DUR_W + 1)'(step_q);
  assign elapsed_sat = elapsed_sum[DUR_W] ? '1 : elapsed_sum[DUR_W-1:0];
  assign twice_t     = {t_q, 1'b0};

  // sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    prog_d    = prog_q;
    prev_d    = prev_q;
    fade_d    = fade_q;
    kind_d    = kind_q;
    len_d     = len_q;
    elapsed_d = elapsed_q;
    mid_d     = mid_q;
    level_d   = level_q;
    took_d    = took_q;
    end_d     = end_q;
    ign_d     = ign_q;
    t_d       = t_q;
    out_load  = 1'b0;
    div_req.start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        took_d  = 1'b0;
        end_d   = 1'b0;
        ign_d   = 1'b0;
        t_d     = '0;
        state_d = ST_RESP;
        case (func_q)
          FN_STAGE: begin
            prev_d = look_q;
          end
          FN_CUT: begin
            if (busy) begin
              ign_d = 1'b1;
            end else begin
              if (fade_q) begin
                fade_d  = 1'b0;
                level_d = ONE_Q;
              end
              prog_d = prev_q;
              if (prog_q != '0) begin
                prev_d = prog_q;
              end
              took_d = 1'b1;
            end
          end
          FN_AUTO: begin
            if (busy || (prev_q == '0)) begin
              ign_d = 1'b1;
            end else begin
              mid_d         = 1'b0;
              kind_d        = KIND_AUTO;
              len_d         = len_new;
              elapsed_d     = '0;
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
          end
          FN_FTB: begin
            if (busy) begin
              ign_d = 1'b1;
            end else begin
              kind_d        = fade_q ? KIND_FFB : KIND_FTB;
              len_d         = len_new;
              elapsed_d     = '0;
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
          end
          FN_SWAP: begin
            if (busy) begin
              ign_d = 1'b1;
            end else begin
              prog_d = prev_q;
              prev_d = prog_q;
            end
          end
          FN_REPL: begin
            if (busy || (look_q == '0)) begin
              ign_d = 1'b1;
            end else begin
              prog_d = look_q;
            end
          end
          FN_TICK: begin
            if (busy) begin
              elapsed_d     = elapsed_sat;
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
          end
          default: begin
            ign_d = 1'b1;
          end
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          t_d     = div_rsp.quotient;
          state_d = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        case (kind_q)
          KIND_AUTO: begin
            if (t_q < HALF_Q) begin
              level_d = ONE_Q - twice_t[QW-1:0];
            end else begin
              level_d = QW'(twice_t - {1'b0, ONE_Q});
            end
            // commit once at the midpoint
            if (!mid_q && (t_q >= HALF_Q)) begin
              mid_d  = 1'b1;
              prog_d = prev_q;
              if (prog_q != '0) begin
                prev_d = prog_q;
              end
              took_d = 1'b1;
            end
          end
          KIND_FTB: level_d = ONE_Q - t_q;
          KIND_FFB: level_d = t_q;
          default: ;
        endcase
        // transition complete
        if (t_q >= ONE_Q) begin
          case (kind_q)
            KIND_FTB: begin
              fade_d  = 1'b1;
              level_d = '0;
            end
            KIND_FFB: begin
              fade_d  = 1'b0;
              level_d = ONE_Q;
            end
            KIND_AUTO: level_d = ONE_Q;
            default: ;
          endcase
          kind_d = KIND_NONE;
          end_d  = 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    div_req.dividend = elapsed_d;
    div_req.divisor  = len_d;
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_o.ready);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // bus and transition state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dur_q   <= DUR_W'(60);
      prog_q      <= '0;
      prev_q      <= '0;
      fade_q      <= 1'b0;
      kind_q      <= KIND_NONE;
      len_q       <= '0;
      elapsed_q   <= '0;
      mid_q       <= 1'b0;
      level_q     <= ONE_Q;
      took_q      <= 1'b0;
      end_q       <= 1'b0;
      ign_q       <= 1'b0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        min_dur_q <= cfg_i.min_duration_ms;
      end
      prog_q      <= prog_d;
      prev_q      <= prev_d;
      fade_q      <= fade_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      elapsed_q   <= elapsed_d;
      mid_q       <= mid_d;
      level_q     <= level_d;
      took_q      <= took_d;
      end_q       <= end_d;
      ign_q       <= ign_d;
      t_q         <= t_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command word capture
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= in_i.func;
      look_q <= in_i.look_id;
      dur_q  <= in_i.duration_ms;
      step_q <= in_i.step_ms;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.program_look <= prog_q;
      out_o.preview_look <= prev_q;
      out_o.opacity      <= level_q;
      out_o.progress     <= t_q;
      out_o.kind         <= kind_q;
      out_o.ftb_active   <= fade_q;
      out_o.took_program <= took_q;
      out_o.ended        <= end_q;
      out_o.ignored      <= ign_q;
    end
  end

  assign out_o.valid = out_valid_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= ONE_Q)
    else $error("opacity above one");

  a_ftb_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == KIND_FTB) |-> !fade_q)
    else $error("fade to black running while already held black");

  a_ffb_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == KIND_FFB) |-> fade_q)
    else $error("fade from black running while not held black");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider result outside the wait state");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_EXEC))
    else $error("accepted word not executed");

endmodule
